@@ sv/dpwp_pkg.sv @@
`default_nettype none
package dpwp_pkg;

  // Default frame size and coordinate fraction
  localparam int MaxRowsDef  = 2048;
  localparam int MaxColsDef  = 2048;
  localparam int FracBitsDef = 12;

  // Field widths
  localparam int RowW  = 11;
  localparam int ColW  = 11;
  localparam int RawW  = 16;
  localparam int CoordW = 32;
  localparam int GrayW = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;

  // Gray scale and divider widths
  localparam int GrayMax = 255;
  localparam int NumW    = 41;
  localparam int DenW    = 33;

  // Register map
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEPTH_OFFSET = 3'd0,
    CFG_DEPTH_GAIN   = 3'd1,
    CFG_INV_FOCAL    = 3'd2,
    CFG_PRINCIPAL    = 3'd3,
    CFG_ROT_QUAT     = 3'd4,
    CFG_TRANSLATION  = 3'd5,
    CFG_Z_LOWER      = 3'd6,
    CFG_Z_UPPER      = 3'd7
  } cfg_idx_e;

  localparam logic [63:0] QuatReset  = 64'h4000_0000_0000_0000;
  localparam logic [31:0] ZUpperReset = 32'd4096;

  // Clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Payload carried through the gray divider
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
    logic [DenW-1:0]    den;
    logic [NumW-1:0]    rem;
    logic [GrayW-1:0]   quo;
  } div_t;

endpackage
`default_nettype wire

@@ sv/depth_pixel_to_world_point.sv @@
`default_nettype none
// Depth pixel to world point. Each accepted pixel (row, column, raw depth) is
// scaled to depth, back-projected through a pinhole camera, rotated by the
// configured quaternion and translated; it yields one point with a gray level
// when the pixel is in frame and world z is above z_lower, otherwise nothing.
// The pipeline takes one pixel every clock unless the output stalls and has 7
// arithmetic stages (scale, back-projection, rotation, translation) and then 8
// stages of a one-bit-per-stage restoring divider for the gray level, the last
// of which is the output register. A stall at the output holds every stage.
// The user must write configuration registers only while the pipeline is
// empty, which the block does not enforce; the rotation matrix is registered.
module depth_pixel_to_world_point #(
  parameter int MAX_ROWS  = dpwp_pkg::MaxRowsDef,
  parameter int MAX_COLS  = dpwp_pkg::MaxColsDef,
  parameter int FRAC_BITS = dpwp_pkg::FracBitsDef
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [dpwp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [dpwp_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire                               pixel_valid_i,
  output logic                              pixel_ready_o,
  input  wire  [dpwp_pkg::RowW-1:0]         pixel_row_i,
  input  wire  [dpwp_pkg::ColW-1:0]         pixel_col_i,
  input  wire  [dpwp_pkg::RawW-1:0]         depth_raw_i,
  output logic                              point_valid_o,
  input  wire                               point_ready_i,
  output logic signed [dpwp_pkg::CoordW-1:0] point_x_o,
  output logic signed [dpwp_pkg::CoordW-1:0] point_y_o,
  output logic signed [dpwp_pkg::CoordW-1:0] point_z_o,
  output logic [dpwp_pkg::GrayW-1:0]        gray_level_o
);
  import dpwp_pkg::*;

  localparam int DSh  = 24 - FRAC_BITS;
  localparam int TUp  = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
  localparam int TDn  = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
  localparam int NDiv = GrayW;

  // Configuration registers
  logic signed [31:0] offset_q;
  logic [31:0]        gain_q;
  logic [63:0]        ifocal_q;
  logic [31:0]        pp_q;
  logic [63:0]        quat_q;
  logic [62:0]        trans_q;
  logic signed [31:0] zlo_q;
  logic signed [31:0] zhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      gain_q   <= '0;
      ifocal_q <= '0;
      pp_q     <= '0;
      quat_q   <= QuatReset;
      trans_q  <= '0;
      zlo_q    <= '0;
      zhi_q    <= ZUpperReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEPTH_OFFSET: offset_q <= cfg_data_i[31:0];
        CFG_DEPTH_GAIN:   gain_q   <= cfg_data_i[31:0];
        CFG_INV_FOCAL:    ifocal_q <= cfg_data_i;
        CFG_PRINCIPAL:    pp_q     <= cfg_data_i[31:0];
        CFG_ROT_QUAT:     quat_q   <= cfg_data_i;
        CFG_TRANSLATION:  trans_q  <= cfg_data_i[62:0];
        CFG_Z_LOWER:      zlo_q    <= cfg_data_i[31:0];
        CFG_Z_UPPER:      zhi_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Rotation matrix in Q.24 from the quaternion, registered
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
  logic signed [34:0] one28;
  logic signed [34:0] rf [9];
  logic signed [30:0] rot_q [9];

  assign qw = quat_q[63:48];
  assign qx = quat_q[47:32];
  assign qy = quat_q[31:16];
  assign qz = quat_q[15:0];
  assign pxx = qx * qx;
  assign pyy = qy * qy;
  assign pzz = qz * qz;
  assign pxy = qx * qy;
  assign pxz = qx * qz;
  assign pyz = qy * qz;
  assign pwx = qw * qx;
  assign pwy = qw * qy;
  assign pwz = qw * qz;
  assign one28 = 35'sd1 <<< 28;

  always_comb begin
    rf[0] = one28 - 2 * (35'(pyy) + 35'(pzz));
    rf[1] = 2 * (35'(pxy) - 35'(pwz));
    rf[2] = 2 * (35'(pxz) + 35'(pwy));
    rf[3] = 2 * (35'(pxy) + 35'(pwz));
    rf[4] = one28 - 2 * (35'(pxx) + 35'(pzz));
    rf[5] = 2 * (35'(pyz) - 35'(pwx));
    rf[6] = 2 * (35'(pxz) - 35'(pwy));
    rf[7] = 2 * (35'(pyz) + 35'(pwx));
    rf[8] = one28 - 2 * (35'(pxx) + 35'(pyy));
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      rot_q[i] <= 31'(rf[i] >>> 4);
    end
  end

  // Translation scaled to Q.F
  logic signed [20:0] tq [3];
  logic signed [33:0] tr [3];

  assign tq[0] = trans_q[62:42];
  assign tq[1] = trans_q[41:21];
  assign tq[2] = trans_q[20:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tr[i] = (34'(tq[i]) <<< TUp) >>> TDn;
    end
  end

  // Global advance: every stage moves when the output can drain
  logic adv;
  assign adv = !point_valid_o || point_ready_i;
  assign pixel_ready_o = adv;

  // Stage 1: depth gain product and focal products
  logic               in_frame;
  logic signed [17:0] dcx, dcy;
  logic [47:0]        pg_q;
  logic signed [50:0] px_q, py_q;
  logic               v1_q;

  assign in_frame = (int'(pixel_row_i) < MAX_ROWS) && (int'(pixel_col_i) < MAX_COLS);
  assign dcx = $signed({3'b000, pixel_col_i, 4'b0000}) - $signed({2'b00, pp_q[31:16]});
  assign dcy = $signed({3'b000, pixel_row_i, 4'b0000}) - $signed({2'b00, pp_q[15:0]});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pg_q <= gain_q * {16'd0, depth_raw_i};
      px_q <= dcx * $signed({1'b0, ifocal_q[63:32]});
      py_q <= dcy * $signed({1'b0, ifocal_q[31:0]});
    end
  end

  // Stage 2: scaled depth and reciprocal-focal terms
  logic signed [45:0] dsum;
  logic signed [31:0] d2_q, tx2_q, ty2_q;
  logic               v2_q;

  assign dsum = 46'(offset_q) + $signed(46'(pg_q >> DSh));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d2_q  <= sat32(64'(dsum));
      tx2_q <= px_q[49:18];
      ty2_q <= py_q[49:18];
    end
  end

  // Stage 3: depth times focal terms
  logic signed [63:0] ptx_q, pty_q;
  logic signed [31:0] d3_q;
  logic               v3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ptx_q <= tx2_q * d2_q;
      pty_q <= ty2_q * d2_q;
      d3_q  <= d2_q;
    end
  end

  // Stage 4: camera point
  logic signed [31:0] cam_q [3];
  logic               v4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cam_q[0] <= sat32(ptx_q >>> 18);
      cam_q[1] <= sat32(pty_q >>> 18);
      cam_q[2] <= d3_q;
    end
  end

  // Stage 5: matrix products
  logic signed [63:0] mp_q [9];
  logic               v5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        mp_q[i] <= rot_q[i] * cam_q[i % 3];
      end
    end
  end

  // Stage 6: row sums and translation
  logic signed [63:0] rs [3];
  logic signed [40:0] ws [3];
  logic signed [31:0] w_q [3];
  logic               v6_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i] = mp_q[3*i] + mp_q[3*i+1] + mp_q[3*i+2];
      ws[i] = 41'(rs[i] >>> 24) + 41'(tr[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        w_q[i] <= sat32(64'(ws[i]));
      end
    end
  end

  // Stage 7: z window, gray numerator and denominator
  logic signed [32:0] zdiff, zspan;
  div_t               dv [NDiv+1];
  logic               dvv_q [NDiv+1];

  assign zdiff = 33'(w_q[2]) - 33'(zlo_q);
  assign zspan = 33'(zhi_q) - 33'(zlo_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv[0].x   <= w_q[0];
      dv[0].y   <= w_q[1];
      dv[0].z   <= w_q[2];
      dv[0].sat <= w_q[2] > zhi_q;
      dv[0].den <= zspan;
      dv[0].rem <= NumW'(zdiff[31:0]) * NumW'(GrayMax);
      dv[0].quo <= '0;
    end
  end

  // Gray divider: one quotient bit per stage, high bit first
  for (genvar k = 0; k < NDiv; k++) begin : g_div
    localparam int Sh = NDiv - 1 - k;
    logic [NumW-1:0] trial;
    div_t            step_d;
    assign trial = NumW'(dv[k].den) << Sh;

    // Subtract the shifted divisor when it fits and set this quotient bit
    always_comb begin
      step_d = dv[k];
      if (dv[k].rem >= trial) begin
        step_d.rem     = dv[k].rem - trial;
        step_d.quo[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv[k+1] <= step_d;
      end
    end
  end

  // Valid bits; drop pixels outside the frame and points at or below z_lower
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      for (int i = 0; i <= NDiv; i++) begin
        dvv_q[i] <= 1'b0;
      end
    end else if (adv) begin
      v1_q     <= pixel_valid_i && in_frame;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      v6_q     <= v5_q;
      dvv_q[0] <= v6_q && (w_q[2] > zlo_q);
      for (int i = 0; i < NDiv; i++) begin
        dvv_q[i+1] <= dvv_q[i];
      end
    end
  end

  // Output register is the last divider stage
  assign point_valid_o = dvv_q[NDiv];
  assign point_x_o     = dv[NDiv].x;
  assign point_y_o     = dv[NDiv].y;
  assign point_z_o     = dv[NDiv].z;
  assign gray_level_o  = dv[NDiv].sat ? GrayW'(GrayMax) : dv[NDiv].quo;

endmodule
`default_nettype wire
